// ===== rtl/u2af_pkg.sv =====
package u2af_pkg;

  // One input request: a raw byte of UTF-8 text.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [6:0] ascii_char;
    logic       has_char;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  // Work handed from the front to the back for one accepted byte.
  typedef struct packed {
    logic [15:0] cp0;
    logic        cp0_v;
    logic [6:0]  cp1;
    logic        cp1_v;
    logic        done;
  } job_t;

  typedef struct packed {
    logic [1:0] len;
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
  } fold_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [6:0] ChDash  = 7'h2D;
  localparam logic [6:0] ChQuote = 7'h27;
  localparam logic [6:0] ChDquot = 7'h22;
  localparam logic [6:0] ChDot   = 7'h2E;
  localparam logic [6:0] ChSpace = 7'h20;

  // ASCII passes as itself; known punctuation folds to 1..3 characters, all else to none.
  function automatic fold_t fold_lookup(input logic [15:0] cp);
    fold_t f;
    f = '0;
    if (cp[15:7] == 9'd0) begin
      f.len = 2'd1;
      f.c0  = cp[6:0];
    end else begin
      case (cp)
        16'h2014: begin
          f.len = 2'd2; f.c0 = ChDash; f.c1 = ChDash;
        end
        16'h2013, 16'h2012, 16'h2010, 16'h2011: begin
          f.len = 2'd1; f.c0 = ChDash;
        end
        16'h2018, 16'h2019, 16'h201A, 16'h2032: begin
          f.len = 2'd1; f.c0 = ChQuote;
        end
        16'h201C, 16'h201D, 16'h201E, 16'h2033: begin
          f.len = 2'd1; f.c0 = ChDquot;
        end
        16'h2026: begin
          f.len = 2'd3; f.c0 = ChDot; f.c1 = ChDot; f.c2 = ChDot;
        end
        16'h00A0, 16'h2007, 16'h2009, 16'h202F, 16'h200A, 16'h2002, 16'h2003: begin
          f.len = 2'd1; f.c0 = ChSpace;
        end
        default: f = '0;
      endcase
    end
    return f;
  endfunction

endpackage

// ===== rtl/u2af_front.sv =====
module u2af_front import u2af_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output job_t     job,
  output logic     job_push
);

  logic [7:0] held_r [3];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [2:0] need_r, need_nxt;

  logic [7:0] b, lead, x;
  logic       last;
  logic [2:0] need, n;
  logic       complete, close;

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] l;
    l = 3'd1;
    if (c[7:5] == 3'b110) l = 3'd2;
    else if (c[7:4] == 4'b1110) l = 3'd3;
    else if (c[7:3] == 5'b11110) l = 3'd4;
    return l;
  endfunction

  always_comb begin
    b        = item.text_byte;
    last     = item.end_of_text;
    need     = (held_cnt_r == 2'd0) ? seq_len(b) : need_r;
    n        = {1'b0, held_cnt_r} + 3'd1;
    complete = (n >= need);
    close    = complete || last;
    lead     = (held_cnt_r == 2'd0) ? b : held_r[0];
    x        = held_r[1];
    job      = '0;
    job.done = last;
    if (complete) begin
      unique case (need)
        3'd1: begin
          job.cp0   = {8'h00, b};
          job.cp0_v = ~b[7];
        end
        3'd2: begin
          job.cp0   = {5'd0, lead[4:0], b[5:0]};
          job.cp0_v = 1'b1;
        end
        3'd3: begin
          job.cp0   = {lead[3:0], x[5:0], b[5:0]};
          job.cp0_v = 1'b1;
        end
        default: job.cp0_v = 1'b0; // four-byte form: swallowed
      endcase
    end else if (last) begin
      // truncated: lead dropped, the bytes after it decoded on their own
      if (held_cnt_r != 2'd2) begin
        job.cp0   = {8'h00, b};
        job.cp0_v = ~b[7];
      end else if (~x[7]) begin
        job.cp0   = {8'h00, x};
        job.cp0_v = 1'b1;
        job.cp1   = b[6:0];
        job.cp1_v = ~b[7];
      end else if (x[7:5] == 3'b110) begin
        job.cp0   = {5'd0, x[4:0], b[5:0]};
        job.cp0_v = 1'b1;
      end else begin
        job.cp0   = {8'h00, b};
        job.cp0_v = ~b[7];
      end
    end
    job_push = accept && (job.cp0_v || job.cp1_v || job.done);

    held_cnt_nxt = held_cnt_r;
    need_nxt     = need_r;
    if (accept) begin
      if (close) begin
        held_cnt_nxt = 2'd0;
        need_nxt     = 3'd0;
      end else begin
        held_cnt_nxt = held_cnt_r + 2'd1;
        need_nxt     = need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      need_r     <= 3'd0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      need_r     <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !close) begin
      held_r[held_cnt_r] <= b;
    end
  end

  a_held_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd0 |-> {1'b0, held_cnt_r} < need_r)
    else $error("held bytes reach sequence length");

  a_idle_no_need: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r == 2'd0 |-> need_r == 3'd0)
    else $error("sequence length kept with nothing held");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.end_of_text |=> held_cnt_r == 2'd0)
    else $error("state not cleared after final byte");

endmodule

// ===== rtl/u2af_queue.sv =====
module u2af_queue import u2af_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t rd_data,
  output logic empty
);

  job_t           mem_r [QDepth];
  logic [QAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAw:0]   count_r;

  assign full    = (count_r == (QAw+1)'(QDepth));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + QAw'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + QAw'(1);
      if (wr_en && !rd_en) count_r <= count_r + (QAw+1)'(1);
      else if (rd_en && !wr_en) count_r <= count_r - (QAw+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== rtl/u2af_back.sv =====
module u2af_back import u2af_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  logic      head_v,
  output logic      head_pop,
  output out_item_t out_item,
  output logic      out_v,
  input  logic      out_take
);

  fold_t      f;
  logic [1:0] len0;
  logic [2:0] cnt;
  logic [1:0] idx_r, idx_nxt;
  logic       slot_free, step, is_last;
  out_item_t  res;
  out_item_t  out_r;
  logic       out_v_r;

  always_comb begin
    f    = fold_lookup(head.cp0);
    len0 = head.cp0_v ? f.len : 2'd0;
    cnt  = {1'b0, len0} + {2'd0, head.cp1_v} + {2'd0, head.done};

    slot_free = !out_v_r || out_take;
    step      = head_v && (cnt == 3'd0 || slot_free);
    is_last   = ({1'b0, idx_r} == cnt - 3'd1);

    res = '0;
    if (idx_r < len0) begin
      res.has_char = 1'b1;
      unique case (idx_r)
        2'd0:    res.ascii_char = f.c0;
        2'd1:    res.ascii_char = f.c1;
        default: res.ascii_char = f.c2;
      endcase
    end else if (head.cp1_v && idx_r == len0) begin
      res.has_char   = 1'b1;
      res.ascii_char = head.cp1;
    end else begin
      res.text_done = 1'b1;
    end
    res.run_last = is_last;

    head_pop = step && (cnt == 3'd0 || is_last);
    idx_nxt  = idx_r;
    if (step && cnt != 3'd0) idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      out_v_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (step && cnt != 3'd0) out_v_r <= 1'b1;
      else if (out_take) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cnt != 3'd0) out_r <= res;
  end

  assign out_item = out_r;
  assign out_v    = out_v_r;

endmodule

// ===== rtl/utf8_to_ascii_fold_unit.sv =====
// Channel  | Ports                  | Handshake
// input    | push, full, in_item    | taken when push & !full
// result   | empty, pop, out_item   | taken when pop & !empty
//
// The front decodes one byte per cycle unless the queue is full, and queues at
// most one job per byte. The back emits one result per cycle from a registered
// output slot while results are taken; a job yields up to 4 results, or none
// when nothing folds out of it. Results pass through the queue, then the slot.
// Reset (rst_n low, synchronous) empties the 4-job queue and the held bytes.
// full rises only while the queue is full; a stalled result port fills it.
module utf8_to_ascii_fold_unit import u2af_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic accept;
  job_t job, head;
  logic job_push, head_v, head_pop, q_empty, out_v;

  assign accept = push && !full;
  assign head_v = !q_empty;
  assign empty  = !out_v;

  u2af_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .job      (job),
    .job_push (job_push)
  );

  u2af_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  u2af_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_v   (head_v),
    .head_pop (head_pop),
    .out_item (out_item),
    .out_v    (out_v),
    .out_take (pop && out_v)
  );

endmodule

// ===== verif/utf8_to_ascii_fold_unit_test.sv =====
module utf8_to_ascii_fold_unit_test;
  import u2af_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NO_END      = 99;

  localparam logic [6:0] ASCII_DASH  = 7'h2D;
  localparam logic [6:0] ASCII_QUOTE = 7'h27;
  localparam logic [6:0] ASCII_DQUOT = 7'h22;
  localparam logic [6:0] ASCII_DOT   = 7'h2E;
  localparam logic [6:0] ASCII_SPACE = 7'h20;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  utf8_to_ascii_fold_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // Decoder state mirrored from accepted bytes.
  logic [7:0]  held_seq [3];
  int unsigned held_len;
  int unsigned seq_need;
  logic [7:0]  run_buf [4];

  out_item_t   byte_chars[$];
  out_item_t   expected_chars[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_request;
  int unsigned stall_left;
  int unsigned error_count;
  int unsigned cycle_count;
  out_item_t   want;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void add_char(input logic [6:0] ch, input logic has, input logic done);
    out_item_t r;
    r = '0;
    r.ascii_char = ch;
    r.has_char   = has;
    r.text_done  = done;
    byte_chars.push_back(r);
  endfunction

  function automatic void fold_codepoint(input int unsigned cp);
    if (cp < 32'h80) begin
      add_char(cp[6:0], 1'b1, 1'b0);
    end else begin
      case (cp)
        32'h2014: begin
          add_char(ASCII_DASH, 1'b1, 1'b0);
          add_char(ASCII_DASH, 1'b1, 1'b0);
        end
        32'h2013, 32'h2012, 32'h2010, 32'h2011: add_char(ASCII_DASH, 1'b1, 1'b0);
        32'h2018, 32'h2019, 32'h201A, 32'h2032: add_char(ASCII_QUOTE, 1'b1, 1'b0);
        32'h201C, 32'h201D, 32'h201E, 32'h2033: add_char(ASCII_DQUOT, 1'b1, 1'b0);
        32'h2026: begin
          add_char(ASCII_DOT, 1'b1, 1'b0);
          add_char(ASCII_DOT, 1'b1, 1'b0);
          add_char(ASCII_DOT, 1'b1, 1'b0);
        end
        32'h00A0, 32'h2007, 32'h2009, 32'h202F, 32'h200A, 32'h2002, 32'h2003:
          add_char(ASCII_SPACE, 1'b1, 1'b0);
        default: ;
      endcase
    end
  endfunction

  function automatic int unsigned lead_length(input logic [7:0] b);
    int unsigned len;
    casez (b)
      8'b110?_????: len = 2;
      8'b1110_????: len = 3;
      8'b1111_0???: len = 4;
      default:      len = 1;
    endcase
    return len;
  endfunction

  // Decode run_buf[0..n); a lead short of its followers is dropped alone.
  function automatic void decode_run_buf(input int unsigned n);
    int unsigned r;
    int unsigned rem;
    int unsigned cp;
    int unsigned adv;
    logic [7:0]  c;
    r = 0;
    while (r < n) begin
      c   = run_buf[r];
      rem = n - r;
      if (!c[7]) begin
        cp  = 32'(c);
        adv = 1;
      end else if (c[7:5] == 3'b110 && rem >= 2) begin
        cp  = 32'({c[4:0], run_buf[r + 1][5:0]});
        adv = 2;
      end else if (c[7:4] == 4'b1110 && rem >= 3) begin
        cp  = 32'({c[3:0], run_buf[r + 1][5:0], run_buf[r + 2][5:0]});
        adv = 3;
      end else begin
        cp  = 32'hFFFD;
        adv = (c[7:3] == 5'b11110 && rem >= 4) ? 4 : 1;
      end
      r += adv;
      fold_codepoint(cp);
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic eot);
    int unsigned n;
    int unsigned need;
    out_item_t   tail;
    byte_chars.delete();
    for (int unsigned i = 0; i < held_len; i++) run_buf[i] = held_seq[i];
    n = held_len;
    run_buf[n] = b;
    n++;
    need = (held_len == 0) ? lead_length(b) : seq_need;
    if (n >= need || eot) begin
      decode_run_buf(n);
      held_len = 0;
      seq_need = 0;
    end else begin
      held_seq[held_len] = b;
      held_len++;
      seq_need = need;
    end
    if (eot) add_char(7'd0, 1'b0, 1'b1);
    if (byte_chars.size() > 0) begin
      tail = byte_chars.pop_back();
      tail.run_last = 1'b1;
      byte_chars.push_back(tail);
    end
    foreach (byte_chars[i]) expected_chars.push_back(byte_chars[i]);
  endfunction

  // Starts and ends at a falling edge; push stays high into the next request.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    in_item_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    item.text_byte   = b;
    item.end_of_text = eot;
    push    <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(b, eot);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] follower_byte();
    logic [7:0] b;
    if ($urandom_range(7) == 0) b = 8'($urandom_range(255));
    else b = 8'h80 | 8'($urandom_range(63));
    return b;
  endfunction

  function automatic logic [15:0] fold_target(input int unsigned idx);
    logic [15:0] cp;
    case (idx)
      0: cp = 16'h2014;  1: cp = 16'h2013;  2: cp = 16'h2012;  3: cp = 16'h2010;
      4: cp = 16'h2011;  5: cp = 16'h2018;  6: cp = 16'h2019;  7: cp = 16'h201A;
      8: cp = 16'h2032;  9: cp = 16'h201C; 10: cp = 16'h201D; 11: cp = 16'h201E;
      12: cp = 16'h2033; 13: cp = 16'h2026; 14: cp = 16'h00A0; 15: cp = 16'h2007;
      16: cp = 16'h2009; 17: cp = 16'h202F; 18: cp = 16'h200A; 19: cp = 16'h2002;
      default: cp = 16'h2003;
    endcase
    return cp;
  endfunction

  // Mostly well-formed sequences with random content, some noise and cut-offs.
  task automatic send_random_text(input int unsigned n_bytes);
    logic [7:0]  seq [4];
    logic [15:0] cp;
    int unsigned len;
    int unsigned end_at;
    int unsigned kind;
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        seq[0] = 8'($urandom_range(127));
        len = 1;
      end else if (kind < 55) begin
        cp = fold_target($urandom_range(20));
        if (cp < 16'h800) begin
          seq[0] = {3'b110, cp[10:6]};
          seq[1] = {2'b10, cp[5:0]};
          len = 2;
        end else begin
          seq[0] = {4'b1110, cp[15:12]};
          seq[1] = {2'b10, cp[11:6]};
          seq[2] = {2'b10, cp[5:0]};
          len = 3;
        end
      end else if (kind < 65) begin
        seq[0] = 8'hE0 | 8'($urandom_range(15));
        seq[1] = follower_byte();
        seq[2] = follower_byte();
        len = 3;
      end else if (kind < 75) begin
        seq[0] = 8'hC0 | 8'($urandom_range(31));
        seq[1] = follower_byte();
        len = 2;
      end else if (kind < 83) begin
        seq[0] = 8'hF0 | 8'($urandom_range(7));
        seq[1] = follower_byte();
        seq[2] = follower_byte();
        seq[3] = follower_byte();
        len = 4;
      end else if (kind < 92) begin
        seq[0] = 8'($urandom_range(255));
        len = 1;
      end else begin
        // lead with too few followers; whatever comes next completes it
        seq[0] = $urandom_range(1) ? (8'hE0 | 8'($urandom_range(15)))
                                   : (8'hF0 | 8'($urandom_range(7)));
        seq[1] = follower_byte();
        len = 1 + $urandom_range(1);
      end
      end_at = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : NO_END;
      for (int unsigned i = 0; i < len; i++) send_byte(seq[i], i == end_at);
      sent += len;
    end
  endtask

  task automatic test_directed_cases();
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);                        // char then end marker
    send_byte(8'hE2, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h94, 1'b0);  // em dash
    send_byte(8'hE2, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'hA6, 1'b0);  // ellipsis
    send_byte(8'hC2, 1'b0); send_byte(8'hA0, 1'b0);                          // nbsp
    send_byte(8'hC1, 1'b0); send_byte(8'hBF, 1'b0);                          // overlong 7F
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);  // overlong NUL
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);                          // four-byte
    send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);                          // stray bytes
    send_byte(8'hE2, 1'b0); send_byte(8'h80, 1'b1);                          // cut-off text
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_text(input int unsigned n_bytes);
    send_random_text(n_bytes);
    stop_sending();
    wait_drained();
  endtask

  // Result side holds off long enough for the job queue to fill and block input.
  task automatic test_result_stall();
    stall_request = 300;
    send_random_text(30);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_sender_pause();
    send_random_text(8);
    stop_sending();
    wait_drained();
    send_random_text(8);
    send_byte(8'h2E, 1'b1);
    stop_sending();
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("utf8_to_ascii_fold_unit_test: done, errors");
      $finish;
    end else if (rst_n && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: char=%h has=%b last=%b done=%b",
                   out_item.ascii_char, out_item.has_char, out_item.run_last,
                   out_item.text_done);
      end else begin
        want = expected_chars.pop_front();
        if (out_item.ascii_char !== want.ascii_char || out_item.has_char !== want.has_char ||
            out_item.run_last !== want.run_last || out_item.text_done !== want.text_done) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("result mismatch: expected char=%h has=%b last=%b done=%b, got char=%h has=%b last=%b done=%b",
                     want.ascii_char, want.has_char, want.run_last, want.text_done,
                     out_item.ascii_char, out_item.has_char, out_item.run_last,
                     out_item.text_done);
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_item       = '0;
    held_len      = 0;
    seq_need      = 0;
    stall_request = 0;
    stall_left    = 0;
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 11;
    recv_idle_pct = 74;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_random_text(30);

    send_idle_pct = 74;
    recv_idle_pct = 11;
    test_random_text(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(30);
    test_result_stall();
    test_sender_pause();

    repeat (10) @(negedge clk);
    error_count += expected_chars.size();
    if (error_count == 0) begin
      $display("utf8_to_ascii_fold_unit_test: done, clean");
    end else begin
      $display("utf8_to_ascii_fold_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/u2af_pkg.sv
rtl/u2af_front.sv
rtl/u2af_queue.sv
rtl/u2af_back.sv
rtl/utf8_to_ascii_fold_unit.sv
verif/utf8_to_ascii_fold_unit_test.sv
